/* hdl/elf_bid_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ELF build-id extractor.
// No dependencies; imported by the controller, the datapath and the top level.
package elf_bid_pkg;

    // Note header layout
    localparam int unsigned HDR_LEN       = 12;
    localparam logic [31:0] BUILD_ID_TYPE = 32'd3;

    // Drain index/count width, sized for the largest identifier or tail
    localparam int unsigned DRAIN_IDX_W = 6;

    // Extraction modes
    localparam logic [1:0] MODE_GUID = 2'd0;
    localparam logic [1:0] MODE_RAW  = 2'd1;
    localparam logic [1:0] MODE_FOLD = 2'd2;
    localparam logic [1:0] MODE_TAIL = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_TRUNC     = 2'd2;

    // Configuration register indexes
    localparam logic REG_ID_MODE    = 1'b0;
    localparam logic REG_BIG_ENDIAN = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic                   accept;
        logic                   drain_load;
        logic                   drain_last;
        logic                   clear;
        logic [DRAIN_IDX_W-1:0] drain_idx;
    } bid_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic                   out_free;
        logic [DRAIN_IDX_W-1:0] drain_count;
    } bid_sts_t;

    // Round a note size up to a multiple of four, without wrap
    function automatic logic [32:0] pad4(input logic [31:0] a);
        logic [32:0] s;
        s = {1'b0, a} + 33'd3;
        return {s[32:2], 2'b00};
    endfunction

endpackage

/* hdl/elf_bid_in_if.sv */
`timescale 1ns / 1ps
// Input channel for section bytes: valid/ready handshake plus payload.
// No dependencies.
interface elf_bid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] section_byte;
    logic       final_byte;

    modport source (output valid, output section_byte, output final_byte, input ready);
    modport sink   (input valid, input section_byte, input final_byte, output ready);
endinterface

/* hdl/elf_bid_out_if.sv */
`timescale 1ns / 1ps
// Output channel for identifier bytes: valid/ready handshake plus payload.
// No dependencies.
interface elf_bid_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] id_byte;
    logic       end_of_id;
    logic [1:0] id_status;

    modport source (output valid, output id_byte, output end_of_id, output id_status,
                    input ready);
    modport sink   (input valid, input id_byte, input end_of_id, input id_status,
                    output ready);
endinterface

/* hdl/elf_bid_ctrl.sv */
`timescale 1ns / 1ps
// Controller for the build-id extractor: accept/drain state machine.
// Depends on elf_bid_pkg for the command and status structs.
module elf_bid_ctrl
    import elf_bid_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_last,
    output logic     in_ready,
    input  bid_sts_t sts,
    output bid_cmd_t cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                   state_reg, state_next;
    logic [DRAIN_IDX_W-1:0] idx_reg, idx_next;
    logic                   accept;
    logic                   last_load;

    // Take a new item only when the output register can hold a result
    assign in_ready  = (state_reg == ST_IDLE) && sts.out_free;
    assign accept    = in_valid && in_ready;
    assign last_load = (idx_reg == (sts.drain_count - DRAIN_IDX_W'(1)));

    // Sequence the end-of-section results one per free output slot
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd.accept     = accept;
        cmd.drain_load = 1'b0;
        cmd.drain_last = 1'b0;
        cmd.clear      = 1'b0;
        cmd.drain_idx  = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_last)
                begin
                    state_next = ST_DRAIN;
                    idx_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                if (sts.drain_count == '0)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.drain_load = 1'b1;
                    cmd.drain_last = last_load;
                    idx_next       = idx_reg + DRAIN_IDX_W'(1);
                    if (last_load)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* hdl/elf_bid_datapath.sv */
`timescale 1ns / 1ps
// Datapath for the build-id extractor: note parser, id/fold/tail stores,
// result selection and the output register. Depends on elf_bid_pkg.
module elf_bid_datapath
    import elf_bid_pkg::*;
#(
    parameter int unsigned ID_BYTES   = 16,
    parameter int unsigned TAIL_BYTES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] id_mode,
    input  logic       header_big_endian,
    input  logic [7:0] section_byte,
    input  logic       final_byte,
    input  bid_cmd_t   cmd,
    output bid_sts_t   sts,
    input  logic       out_ready,
    output logic       out_valid,
    output logic [7:0] id_byte,
    output logic       end_of_id,
    output logic [1:0] id_status
);

    localparam int unsigned IW   = $clog2(ID_BYTES);
    localparam int unsigned PW   = $clog2(ID_BYTES + 1);
    localparam int unsigned TW   = (TAIL_BYTES > 1) ? $clog2(TAIL_BYTES) : 1;
    localparam int unsigned SW   = $clog2(TAIL_BYTES + 1);
    localparam int unsigned TS_W = DRAIN_IDX_W + 1;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_NAME   = 3'd2;
    localparam logic [2:0] PH_DESC   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_EMPTY  = 3'd5;

    localparam logic [33:0] LEFT_HDR = 34'(HDR_LEN);

    // Parser state
    logic [2:0]  phase_reg, phase_next;
    logic [33:0] left_reg, left_next;
    logic [31:0] desc_len_reg, desc_len_next;
    logic [7:0]  hdr_reg [HDR_LEN];
    logic [7:0]  hdr_full [HDR_LEN];

    // Stores
    logic [7:0]    id_store_reg [ID_BYTES];
    logic [PW-1:0] store_pos_reg;
    logic [7:0]    fold_reg [ID_BYTES];
    logic [IW-1:0] fold_pos_reg;
    logic [7:0]    tail_reg [TAIL_BYTES];
    logic [TW-1:0] tail_wr_reg;
    logic [SW-1:0] seen_reg, seen_next;

    // End-of-section bookkeeping
    logic [1:0]             status_reg, status_next;
    logic [DRAIN_IDX_W-1:0] count_reg, count_next;

    // Output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_end_reg;
    logic [1:0] out_status_reg;

    // Parser combinational values
    logic [33:0] left_eff;
    logic [33:0] left_dec;
    logic [3:0]  hdr_idx;
    logic        hdr_wr;
    logic        store_wr;
    logic        desc_emit;
    logic        desc_done;
    logic [31:0] namesz, descsz, ntype;
    logic [32:0] name_pad, desc_pad;
    logic [33:0] skip_len;

    // Drain read values
    logic [DRAIN_IDX_W-1:0] guid_pos;
    logic [IW-1:0]          guid_idx;
    logic [TS_W-1:0]        tail_start, tail_sum, tail_pos;
    logic [TW-1:0]          tail_idx;
    logic [7:0]             drain_byte;
    logic [1:0]             drain_status;
    logic                   out_free;
    logic                   out_load;

    // Map an output position to its source slot with the GUID byte swap
    function automatic logic [DRAIN_IDX_W-1:0] guid_src(input logic [DRAIN_IDX_W-1:0] k);
        logic [DRAIN_IDX_W-1:0] r;
        r = k;
        if (k < DRAIN_IDX_W'(4) && ID_BYTES >= 4)
            r = DRAIN_IDX_W'(3) - k;
        else if (k >= DRAIN_IDX_W'(4) && k < DRAIN_IDX_W'(6) && ID_BYTES >= 6)
            r = DRAIN_IDX_W'(9) - k;
        else if (k >= DRAIN_IDX_W'(6) && k < DRAIN_IDX_W'(8) && ID_BYTES >= 8)
            r = DRAIN_IDX_W'(13) - k;
        return r;
    endfunction

    // Assemble the full header with the incoming byte in the last slot
    always_comb
    begin
        for (int i = 0; i < HDR_LEN; i++)
        begin
            hdr_full[i] = hdr_reg[i];
        end
        hdr_full[HDR_LEN-1] = section_byte;
        if (header_big_endian)
        begin
            namesz = {hdr_full[0], hdr_full[1], hdr_full[2], hdr_full[3]};
            descsz = {hdr_full[4], hdr_full[5], hdr_full[6], hdr_full[7]};
            ntype  = {hdr_full[8], hdr_full[9], hdr_full[10], hdr_full[11]};
        end
        else
        begin
            namesz = {hdr_full[3], hdr_full[2], hdr_full[1], hdr_full[0]};
            descsz = {hdr_full[7], hdr_full[6], hdr_full[5], hdr_full[4]};
            ntype  = {hdr_full[11], hdr_full[10], hdr_full[9], hdr_full[8]};
        end
        name_pad = pad4(namesz);
        desc_pad = pad4(descsz);
        skip_len = {1'b0, name_pad} + {1'b0, desc_pad};
    end

    // Advance the note parser by one byte
    always_comb
    begin
        phase_next    = phase_reg;
        left_next     = left_reg;
        desc_len_next = desc_len_reg;
        hdr_wr        = 1'b0;
        store_wr      = 1'b0;
        desc_emit     = 1'b0;
        desc_done     = 1'b0;
        left_eff      = (left_reg == '0 || left_reg > LEFT_HDR) ? LEFT_HDR : left_reg;
        left_dec      = (left_reg != '0) ? left_reg - 34'd1 : '0;
        hdr_idx       = 4'(HDR_LEN) - left_eff[3:0];
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (left_eff == 34'd1)
                begin
                    left_next = '0;
                    if (ntype == BUILD_ID_TYPE)
                    begin
                        desc_len_next = descsz;
                        if (descsz == '0)
                        begin
                            phase_next = PH_EMPTY;
                        end
                        else if (name_pad == '0)
                        begin
                            phase_next = PH_DESC;
                            left_next  = {2'b00, descsz};
                        end
                        else
                        begin
                            phase_next = PH_NAME;
                            left_next  = {1'b0, name_pad};
                        end
                    end
                    else if (skip_len == '0)
                    begin
                        phase_next = PH_HEADER;
                        left_next  = LEFT_HDR;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                        left_next  = skip_len;
                    end
                end
                else
                begin
                    hdr_wr    = 1'b1;
                    left_next = left_eff - 34'd1;
                end
            end
            PH_SKIP:
            begin
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = PH_HEADER;
                    left_next  = LEFT_HDR;
                end
            end
            PH_NAME:
            begin
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    left_next  = {2'b00, desc_len_reg};
                    phase_next = (desc_len_reg == '0) ? PH_DONE : PH_DESC;
                end
            end
            PH_DESC:
            begin
                store_wr  = (store_pos_reg < PW'(ID_BYTES));
                left_next = left_dec;
                desc_done = (left_dec == '0);
                desc_emit = (id_mode == MODE_RAW);
                if (desc_done)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Work out the section status and how many results the end brings
    always_comb
    begin
        seen_next = (seen_reg < SW'(TAIL_BYTES)) ? seen_reg + SW'(1) : seen_reg;
        if (phase_next == PH_DONE)
            status_next = STATUS_OK;
        else if (phase_next == PH_EMPTY || phase_next == PH_SKIP)
            status_next = STATUS_NOT_FOUND;
        else if (phase_next == PH_HEADER && left_next == LEFT_HDR)
            status_next = STATUS_NOT_FOUND;
        else
            status_next = STATUS_TRUNC;
        case (id_mode)
            MODE_GUID: count_next = (status_next == STATUS_OK) ? DRAIN_IDX_W'(ID_BYTES)
                                                               : DRAIN_IDX_W'(1);
            MODE_RAW:  count_next = (status_next != STATUS_OK) ? DRAIN_IDX_W'(1) : '0;
            MODE_FOLD: count_next = DRAIN_IDX_W'(ID_BYTES);
            default:   count_next = DRAIN_IDX_W'(seen_next);
        endcase
    end

    // Select the result for the current drain position
    always_comb
    begin
        guid_pos   = guid_src(cmd.drain_idx);
        guid_idx   = guid_pos[IW-1:0];
        tail_start = (seen_reg < SW'(TAIL_BYTES)) ? '0 : TS_W'(tail_wr_reg);
        tail_sum   = tail_start + TS_W'(cmd.drain_idx);
        tail_pos   = (tail_sum >= TS_W'(TAIL_BYTES)) ? tail_sum - TS_W'(TAIL_BYTES) : tail_sum;
        tail_idx   = tail_pos[TW-1:0];
        case (id_mode)
            MODE_GUID:
            begin
                drain_byte   = (status_reg == STATUS_OK) ? id_store_reg[guid_idx] : 8'd0;
                drain_status = status_reg;
            end
            MODE_RAW:
            begin
                drain_byte   = 8'd0;
                drain_status = status_reg;
            end
            MODE_FOLD:
            begin
                drain_byte   = fold_reg[guid_idx];
                drain_status = STATUS_OK;
            end
            default:
            begin
                drain_byte   = tail_reg[tail_idx];
                drain_status = STATUS_OK;
            end
        endcase
    end

    assign out_free        = !out_valid_reg || out_ready;
    assign out_load        = cmd.drain_load || (cmd.accept && desc_emit);
    assign sts.out_free    = out_free;
    assign sts.drain_count = count_reg;

    assign out_valid = out_valid_reg;
    assign id_byte   = out_byte_reg;
    assign end_of_id = out_end_reg;
    assign id_status = out_status_reg;

    // Control state and zero-reset stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            left_reg      <= LEFT_HDR;
            desc_len_reg  <= '0;
            store_pos_reg <= '0;
            fold_pos_reg  <= '0;
            tail_wr_reg   <= '0;
            seen_reg      <= '0;
            status_reg    <= STATUS_OK;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ID_BYTES; i++)
            begin
                id_store_reg[i] <= '0;
                fold_reg[i]     <= '0;
            end
        end
        else
        begin
            // Drop the result once taken, or replace it
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.clear)
            begin
                phase_reg     <= PH_HEADER;
                left_reg      <= LEFT_HDR;
                desc_len_reg  <= '0;
                store_pos_reg <= '0;
                fold_pos_reg  <= '0;
                tail_wr_reg   <= '0;
                seen_reg      <= '0;
                for (int i = 0; i < ID_BYTES; i++)
                begin
                    id_store_reg[i] <= '0;
                    fold_reg[i]     <= '0;
                end
            end
            else if (cmd.accept)
            begin
                phase_reg    <= phase_next;
                left_reg     <= left_next;
                desc_len_reg <= desc_len_next;
                seen_reg     <= seen_next;
                // Fold every byte into its slot
                fold_reg[fold_pos_reg] <= fold_reg[fold_pos_reg] ^ section_byte;
                fold_pos_reg <= (fold_pos_reg == IW'(ID_BYTES - 1)) ? '0
                                                                    : fold_pos_reg + IW'(1);
                tail_wr_reg  <= (tail_wr_reg == TW'(TAIL_BYTES - 1)) ? '0
                                                                     : tail_wr_reg + TW'(1);
                if (store_wr)
                begin
                    id_store_reg[store_pos_reg[IW-1:0]] <= section_byte;
                    store_pos_reg <= store_pos_reg + PW'(1);
                end
                // Hold the end-of-section summary for the drain
                if (final_byte)
                begin
                    status_reg <= status_next;
                    count_reg  <= count_next;
                end
            end
        end
    end

    // Payload registers: header bytes, tail ring and output fields
    always_ff @(posedge clk)
    begin
        if (cmd.accept && hdr_wr)
            hdr_reg[hdr_idx] <= section_byte;
        if (cmd.accept && !cmd.clear)
            tail_reg[tail_wr_reg] <= section_byte;
        if (cmd.drain_load)
        begin
            out_byte_reg   <= drain_byte;
            out_end_reg    <= cmd.drain_last;
            out_status_reg <= drain_status;
        end
        else if (cmd.accept && desc_emit)
        begin
            out_byte_reg   <= section_byte;
            out_end_reg    <= desc_done;
            out_status_reg <= STATUS_OK;
        end
    end

endmodule

/* hdl/elf_build_id_extractor.sv */
`timescale 1ns / 1ps
// ELF build-id extractor, top level: APB registers, controller and datapath.
// A byte is taken while the controller is idle and the output register is free; a raw descriptor
// byte appears as a result in the cycle after it is taken.
// A final byte starts a drain of up to max(ID_BYTES, TAIL_BYTES) results, loaded from the drain
// state one per cycle as the output register frees; the section clears with the last result, or
// from the drain state alone when it brings none. No byte is taken meanwhile.
// rst_n (async, low) clears the parser, the id and fold stores and the registers.
module elf_build_id_extractor
    import elf_bid_pkg::*;
#(
    parameter int unsigned ID_BYTES   = 16,
    parameter int unsigned TAIL_BYTES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    elf_bid_in_if.sink            sec_in,
    elf_bid_out_if.source         id_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [1:0] id_mode_reg;
    logic       big_endian_reg;
    logic       cfg_wr;
    logic       in_ready;
    bid_cmd_t   cmd;
    bid_sts_t   sts;

    // Register file: write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_mode_reg    <= MODE_GUID;
            big_endian_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ID_MODE:    id_mode_reg    <= pwdata[1:0];
                REG_BIG_ENDIAN: big_endian_reg <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ID_MODE:    prdata = {30'd0, id_mode_reg};
            REG_BIG_ENDIAN: prdata = {31'd0, big_endian_reg};
            default:        prdata = '0;
        endcase
    end

    assign sec_in.ready = in_ready;

    elf_bid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sec_in.valid),
        .in_last  (sec_in.final_byte),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    elf_bid_datapath #(
        .ID_BYTES   (ID_BYTES),
        .TAIL_BYTES (TAIL_BYTES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .id_mode           (id_mode_reg),
        .header_big_endian (big_endian_reg),
        .section_byte      (sec_in.section_byte),
        .final_byte        (sec_in.final_byte),
        .cmd               (cmd),
        .sts               (sts),
        .out_ready         (id_out.ready),
        .out_valid         (id_out.valid),
        .id_byte           (id_out.id_byte),
        .end_of_id         (id_out.end_of_id),
        .id_status         (id_out.id_status)
    );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the ELF build-id extractor: note parsing, GUID and raw
// extraction, XOR fold and tail modes. Depends on elf_bid_pkg and both channel interfaces.
module tb_top
    import elf_bid_pkg::*;
();

    localparam int unsigned ID_LEN         = 16;
    localparam int unsigned TAIL_LEN       = 16;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned RANDOM_BYTES   = 1;

    // Parser phases of the bench's own note walker
    typedef enum logic [2:0] {
        SCAN_HEADER,
        SCAN_SKIP,
        SCAN_NAME,
        SCAN_DESC,
        SCAN_DONE,
        SCAN_EMPTY
    } scan_phase_e;

    typedef struct packed {
        logic [7:0] id_byte;
        logic       end_of_id;
        logic [1:0] id_status;
    } id_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    elf_bid_in_if  sec_if ();
    elf_bid_out_if id_if ();

    elf_build_id_extractor #(
        .ID_BYTES   (ID_LEN),
        .TAIL_BYTES (TAIL_LEN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sec_in  (sec_if.sink),
        .id_out  (id_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Configuration as the bench believes it
    logic [1:0]  cfg_mode;
    logic        cfg_big;

    // Note walker and extraction trackers
    scan_phase_e scan_phase;
    logic [7:0]  hdr_buf [HDR_LEN];
    logic [34:0] left_cnt;
    logic [31:0] desc_len;
    logic [7:0]  id_store [ID_LEN];
    int unsigned store_pos;
    logic [7:0]  fold_acc [ID_LEN];
    int unsigned fold_idx;
    logic [7:0]  tail_ring [TAIL_LEN];
    int unsigned tail_idx;
    int unsigned tail_count;

    id_result_t  id_expect_q [$];

    int unsigned fail_count;
    int unsigned results_seen;
    int unsigned bytes_taken;
    int unsigned sections_sent;
    int unsigned random_bytes;
    int unsigned idle_cycles;
    bit          steady;

    // Cycles one side waits before the next item
    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic [34:0] round4(input logic [31:0] a);
        return ({3'b000, a} + 35'd3) & ~35'd3;
    endfunction

    function automatic logic [31:0] hdr_word(input int k);
        logic [7:0] b0, b1, b2, b3;
        b0 = hdr_buf[k * 4];
        b1 = hdr_buf[k * 4 + 1];
        b2 = hdr_buf[k * 4 + 2];
        b3 = hdr_buf[k * 4 + 3];
        return cfg_big ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

    function automatic int guid_src(input int i);
        if (i < 4)
            return 3 - i;
        if (i < 6)
            return 9 - i;
        if (i < 8)
            return 13 - i;
        return i;
    endfunction

    function automatic void push_expect(input logic [7:0] b, input logic e, input logic [1:0] s);
        id_result_t r;
        r.id_byte   = b;
        r.end_of_id = e;
        r.id_status = s;
        id_expect_q.push_back(r);
    endfunction

    function automatic void clear_section();
        scan_phase = SCAN_HEADER;
        left_cnt   = 35'(HDR_LEN);
        desc_len   = '0;
        store_pos  = 0;
        fold_idx   = 0;
        tail_idx   = 0;
        tail_count = 0;
        for (int i = 0; i < HDR_LEN; i++)
            hdr_buf[i] = '0;
        for (int i = 0; i < ID_LEN; i++)
        begin
            id_store[i] = '0;
            fold_acc[i] = '0;
        end
        for (int i = 0; i < TAIL_LEN; i++)
            tail_ring[i] = '0;
    endfunction

    // Decode a complete note header and pick the next phase
    function automatic void finish_header();
        logic [31:0] nsz, dsz, ntype;
        nsz   = hdr_word(0);
        dsz   = hdr_word(1);
        ntype = hdr_word(2);
        if (ntype == BUILD_ID_TYPE)
        begin
            desc_len = dsz;
            if (dsz == 0)
                scan_phase = SCAN_EMPTY;
            else
            begin
                left_cnt = round4(nsz);
                if (left_cnt == 0)
                begin
                    scan_phase = SCAN_DESC;
                    left_cnt   = {3'b000, dsz};
                end
                else
                    scan_phase = SCAN_NAME;
            end
        end
        else
        begin
            left_cnt = round4(nsz) + round4(dsz);
            if (left_cnt == 0)
            begin
                scan_phase = SCAN_HEADER;
                left_cnt   = 35'(HDR_LEN);
            end
            else
                scan_phase = SCAN_SKIP;
        end
    endfunction

    // Advance the trackers by one section byte and queue the results it causes
    function automatic void predict_byte(input logic [7:0] data, input logic last_flag);
        logic       done;
        logic [1:0] status;
        int         start;

        fold_acc[fold_idx] ^= data;
        fold_idx = (fold_idx + 1 >= ID_LEN) ? 0 : fold_idx + 1;
        tail_ring[tail_idx] = data;
        tail_idx = (tail_idx + 1 >= TAIL_LEN) ? 0 : tail_idx + 1;
        if (tail_count < TAIL_LEN)
            tail_count++;

        case (scan_phase)
            SCAN_HEADER:
            begin
                if (left_cnt == 0 || left_cnt > HDR_LEN)
                    left_cnt = 35'(HDR_LEN);
                hdr_buf[HDR_LEN - left_cnt] = data;
                left_cnt--;
                if (left_cnt == 0)
                    finish_header();
            end
            SCAN_SKIP:
            begin
                if (left_cnt > 0)
                    left_cnt--;
                if (left_cnt == 0)
                begin
                    scan_phase = SCAN_HEADER;
                    left_cnt   = 35'(HDR_LEN);
                end
            end
            SCAN_NAME:
            begin
                if (left_cnt > 0)
                    left_cnt--;
                if (left_cnt == 0)
                begin
                    scan_phase = SCAN_DESC;
                    left_cnt   = {3'b000, desc_len};
                    if (left_cnt == 0)
                        scan_phase = SCAN_DONE;
                end
            end
            SCAN_DESC:
            begin
                if (store_pos < ID_LEN)
                begin
                    id_store[store_pos] = data;
                    store_pos++;
                end
                if (left_cnt > 0)
                    left_cnt--;
                done = (left_cnt == 0);
                if (cfg_mode == MODE_RAW)
                    push_expect(data, done, STATUS_OK);
                if (done)
                    scan_phase = SCAN_DONE;
            end
            default:
            begin
            end
        endcase

        if (last_flag)
        begin
            if (scan_phase == SCAN_DONE)
                status = STATUS_OK;
            else if (scan_phase == SCAN_EMPTY || scan_phase == SCAN_SKIP)
                status = STATUS_NOT_FOUND;
            else if (scan_phase == SCAN_HEADER && left_cnt == HDR_LEN)
                status = STATUS_NOT_FOUND;
            else
                status = STATUS_TRUNC;

            case (cfg_mode)
                MODE_GUID:
                begin
                    if (status == STATUS_OK)
                        for (int i = 0; i < ID_LEN; i++)
                            push_expect(id_store[guid_src(i)], i == ID_LEN - 1, STATUS_OK);
                    else
                        push_expect(8'h00, 1'b1, status);
                end
                MODE_RAW:
                begin
                    if (status != STATUS_OK)
                        push_expect(8'h00, 1'b1, status);
                end
                MODE_FOLD:
                begin
                    for (int i = 0; i < ID_LEN; i++)
                        push_expect(fold_acc[guid_src(i)], i == ID_LEN - 1, STATUS_OK);
                end
                default:
                begin
                    start = (tail_count < TAIL_LEN) ? 0 : tail_idx;
                    for (int i = 0; i < tail_count; i++)
                        push_expect(tail_ring[(start + i) % TAIL_LEN], i == tail_count - 1,
                                    STATUS_OK);
                end
            endcase
            clear_section();
        end
    endfunction

    // Compare one delivered result with the oldest expectation
    function automatic void check_result(input id_result_t got);
        id_result_t want;
        results_seen++;
        if (id_expect_q.size() == 0)
        begin
            if (fail_count < 10)
                $display("Unexpected result: id_byte %02h end_of_id %0b id_status %0d",
                         got.id_byte, got.end_of_id, got.id_status);
            fail_count++;
        end
        else
        begin
            want = id_expect_q.pop_front();
            if (got.id_byte !== want.id_byte || got.end_of_id !== want.end_of_id ||
                got.id_status !== want.id_status)
            begin
                if (fail_count < 10)
                    $display("Mismatch on result %0d: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                             results_seen, want.id_byte, want.end_of_id, want.id_status,
                             got.id_byte, got.end_of_id, got.id_status);
                fail_count++;
            end
        end
    endfunction

    // Check delivered results first, then predict from the byte taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (id_if.valid && id_if.ready)
                check_result({id_if.id_byte, id_if.end_of_id, id_if.id_status});
            if (sec_if.valid && sec_if.ready)
            begin
                bytes_taken++;
                predict_byte(sec_if.section_byte, sec_if.final_byte);
            end
        end
    end

    // Abort when no handshake of any kind happens for too long
    always @(posedge clk)
    begin
        if ((sec_if.valid && sec_if.ready) || (id_if.valid && id_if.ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: hold off ready for a drawn number of cycles per item
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = draw_wait();
            if (hold > 0)
            begin
                id_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            id_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(id_if.valid && id_if.ready));
        end
    end

    task automatic send_item(input logic [7:0] data, input logic last_flag);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            sec_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sec_if.valid        <= 1'b1;
        sec_if.section_byte <= data;
        sec_if.final_byte   <= last_flag;
        do
            @(posedge clk);
        while (!sec_if.ready);
    endtask

    // Send count bytes from first on; the section's last byte carries the final flag
    task automatic send_bytes(ref logic [7:0] sq[$], input int first, input int count);
        for (int i = first; i < first + count; i++)
            send_item(sq[i], i == sq.size() - 1);
        if (first + count == sq.size())
            sections_sent++;
    endtask

    // Drop valid and wait until every expected result is in and the block has settled
    task automatic wait_idle();
        sec_if.valid <= 1'b0;
        @(posedge clk);
        while (id_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] val);
        logic [31:0] junk;
        junk = $urandom();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (idx == REG_ID_MODE) ? {junk[31:2], val} : {junk[31:1], val[0]};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ID_MODE)
            cfg_mode = val;
        else
            cfg_big = val[0];
    endtask

    task automatic set_config(input logic [1:0] mode, input logic big);
        wait_idle();
        write_reg(REG_ID_MODE, mode);
        write_reg(REG_BIG_ENDIAN, {1'b0, big});
    endtask

    function automatic logic [31:0] other_type();
        logic [31:0] t;
        t = $urandom_range(0, 1) ? 32'($urandom_range(0, 8)) : $urandom();
        if (t == BUILD_ID_TYPE)
            t = 32'd1;
        return t;
    endfunction

    // Append a note header and, for modest sizes, its padded body of random bytes
    task automatic add_note(ref logic [7:0] sq[$], input logic [31:0] nsz,
                            input logic [31:0] dsz, input logic [31:0] ntype, input logic big);
        logic [31:0] words [3];
        int          body;
        words = '{nsz, dsz, ntype};
        for (int w = 0; w < 3; w++)
            for (int j = 0; j < 4; j++)
                sq.push_back(big ? words[w][31 - 8 * j -: 8] : words[w][8 * j +: 8]);
        if (nsz < 256 && dsz < 256)
        begin
            body = int'(round4(nsz) + round4(dsz));
            repeat (body) sq.push_back(8'($urandom()));
        end
    endtask

    task automatic add_noise(ref logic [7:0] sq[$], input int count);
        repeat (count) sq.push_back(8'($urandom()));
    endtask

    task automatic test_guid_note();
        logic [7:0] sq[$];
        set_config(MODE_GUID, 1'b0);
        // Short descriptor: zero padded up to the identifier length
        add_note(sq, 32'd4, 32'd6, BUILD_ID_TYPE, 1'b0);
        send_bytes(sq, 0, sq.size());
        // No name and a descriptor longer than the identifier
        sq.delete();
        add_note(sq, 32'd0, 32'd20, BUILD_ID_TYPE, 1'b0);
        send_bytes(sq, 0, sq.size());
    endtask

    task automatic test_raw_note();
        logic [7:0] sq[$];
        set_config(MODE_RAW, 1'b1);
        add_note(sq, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b1);
        add_note(sq, 32'd0, 32'd20, BUILD_ID_TYPE, 1'b1);
        send_bytes(sq, 0, sq.size());
        // Cut inside the descriptor: streamed bytes, then a truncation status
        sq.delete();
        add_note(sq, 32'd4, 32'd8, BUILD_ID_TYPE, 1'b1);
        sq = sq[0:18];
        send_bytes(sq, 0, sq.size());
    endtask

    task automatic test_status_cases();
        logic [7:0] sq[$];
        set_config(MODE_GUID, 1'b0);
        // Build-id note with an empty descriptor
        add_note(sq, 32'd4, 32'd0, BUILD_ID_TYPE, 1'b0);
        send_bytes(sq, 0, sq.size());
        // Section ends on a note boundary with no build-id note
        sq.delete();
        add_note(sq, 32'd0, 32'd0, 32'd1, 1'b0);
        send_bytes(sq, 0, sq.size());
        // Section ends inside a header
        sq.delete();
        add_noise(sq, 5);
        send_bytes(sq, 0, sq.size());
        // Largest sizes: padding must not wrap, section ends while skipping
        sq.delete();
        add_note(sq, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 1'b0);
        add_noise(sq, 3);
        send_bytes(sq, 0, sq.size());
        // Build-id note whose name runs past the end of the section
        sq.delete();
        add_note(sq, 32'hFFFF_FFFD, 32'd4, BUILD_ID_TYPE, 1'b0);
        add_noise(sq, 2);
        send_bytes(sq, 0, sq.size());
        // Missing note in raw mode
        set_config(MODE_RAW, 1'b0);
        sq.delete();
        add_note(sq, 32'd2, 32'd3, 32'd0, 1'b0);
        send_bytes(sq, 0, sq.size());
    endtask

    task automatic test_fold_tail();
        logic [7:0] sq[$];
        set_config(MODE_FOLD, 1'b0);
        for (int i = 0; i < 20; i++)
            sq.push_back((i % 2 == 0) ? 8'hFF : 8'h00);
        add_noise(sq, 4);
        send_bytes(sq, 0, sq.size());
        set_config(MODE_TAIL, 1'b1);
        sq.delete();
        add_noise(sq, 1);
        send_bytes(sq, 0, sq.size());
        sq.delete();
        add_noise(sq, 21);
        send_bytes(sq, 0, sq.size());
    endtask

    // Registers change between bytes of one section; each byte uses them as they stand
    task automatic test_mid_section_switch();
        logic [7:0] sq[$];
        set_config(MODE_GUID, 1'b0);
        add_note(sq, 32'd4, 32'd8, BUILD_ID_TYPE, 1'b0);
        send_bytes(sq, 0, 16);
        wait_idle();
        write_reg(REG_ID_MODE, MODE_RAW);
        send_bytes(sq, 16, sq.size() - 16);
        // Byte order flips halfway through a header
        set_config(MODE_GUID, 1'b0);
        sq.delete();
        add_note(sq, 32'd0, 32'd5, BUILD_ID_TYPE, 1'b1);
        send_bytes(sq, 0, 6);
        wait_idle();
        write_reg(REG_BIG_ENDIAN, 2'd1);
        send_bytes(sq, 6, sq.size() - 6);
    endtask

    task automatic test_random_sections();
        logic [7:0]  sq[$];
        logic        big;
        int          kind;
        int          cut;
        while (random_bytes < RANDOM_BYTES)
        begin
            set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            steady = ($urandom_range(0, 3) == 0);
            big    = ($urandom_range(0, 7) == 0) ? !cfg_big : cfg_big;
            sq.delete();
            kind = $urandom_range(0, 9);
            if (kind == 9)
                add_noise(sq, $urandom_range(1, 24));
            else if (kind == 6)
            begin
                repeat ($urandom_range(1, 2))
                    add_note(sq, $urandom_range(0, 8), $urandom_range(0, 12), other_type(), big);
            end
            else
            begin
                repeat ($urandom_range(0, 2) == 0 ? 1 : 0)
                    add_note(sq, $urandom_range(0, 8), $urandom_range(0, 12), other_type(), big);
                add_note(sq, $urandom_range(0, 8), (kind == 7) ? 0 : $urandom_range(1, 24),
                         BUILD_ID_TYPE, big);
                if ($urandom_range(0, 3) == 0)
                    add_note(sq, $urandom_range(0, 4), $urandom_range(0, 4), other_type(), big);
                if (kind == 8)
                begin
                    cut = $urandom_range(1, sq.size());
                    sq  = sq[0:cut - 1];
                end
            end
            send_bytes(sq, 0, sq.size());
            random_bytes += sq.size();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        sec_if.valid        = 1'b0;
        sec_if.section_byte = '0;
        sec_if.final_byte   = 1'b0;
        id_if.ready         = 1'b0;
        cfg_mode            = MODE_GUID;
        cfg_big             = 1'b0;
        fail_count          = 0;
        results_seen        = 0;
        bytes_taken         = 0;
        sections_sent       = 0;
        random_bytes        = 0;
        idle_cycles         = 0;
        steady              = 1'b0;
        clear_section();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_guid_note();
        test_raw_note();
        test_status_cases();
        test_fold_tail();
        test_mid_section_switch();
        test_random_sections();

        wait_idle();
        if (id_expect_q.size() != 0)
        begin
            $display("%0d expected results never arrived", id_expect_q.size());
            fail_count++;
        end
        $display("Sent %0d section bytes in %0d sections over all four modes and both byte orders",
                 bytes_taken, sections_sent);
        $display("Checked %0d identifier results, %0d failures", results_seen, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
